// ----- rtl/mfx_pkg.sv -----
`default_nettype none
package mfx_pkg;

	localparam int DW    = 32;
	localparam int FB    = 16;
	localparam int NUM_W = DW + FB;
	localparam int GW    = 18;
	localparam int CFG_W = 31;
	localparam int IDX_W = 2;

	typedef logic signed [DW-1:0] fx_t;

	typedef enum logic [IDX_W-1:0] {
		REG_GAMMA       = 2'd0,
		REG_CLEAN_EN    = 2'd1,
		REG_CLEAN_SPEED = 2'd2
	} reg_idx_t;

	typedef struct packed {
		fx_t density;
		fx_t momentum_x;
		fx_t momentum_y;
		fx_t momentum_z;
		fx_t total_energy;
		fx_t field_x;
		fx_t field_y;
		fx_t field_z;
		fx_t cleaning_scalar;
	} cell_t;

	typedef struct packed {
		fx_t flux_mass;
		fx_t flux_mom_x;
		fx_t flux_mom_y;
		fx_t flux_mom_z;
		fx_t flux_energy;
		fx_t flux_field_x;
		fx_t flux_field_y;
		fx_t flux_field_z;
		fx_t flux_cleaning;
	} flux_t;

	localparam fx_t F_MAX = {1'b0, {(DW-1){1'b1}}};
	localparam fx_t F_MIN = {1'b1, {(DW-1){1'b0}}};
	localparam fx_t F_ONE = fx_t'(64'sd1 <<< FB);
	localparam fx_t F_LSB = fx_t'(1);
	localparam logic signed [2*DW-1:0] W_MAX = (2*DW)'((64'sd1 <<< (DW-1)) - 64'sd1);
	localparam logic signed [2*DW-1:0] W_MIN = -W_MAX - (2*DW)'(1);
	localparam logic signed [2*DW-1:0] RND   = (2*DW)'((64'sd1 <<< FB) - 64'sd1);

	function automatic fx_t sat_wide(input logic signed [2*DW-1:0] v);
		if (v > W_MAX) return F_MAX;
		else if (v < W_MIN) return F_MIN;
		else return v[DW-1:0];
	endfunction

	function automatic fx_t sadd(input fx_t a, input fx_t b);
		logic [DW:0] s;
		s = {a[DW-1], a} + {b[DW-1], b};
		if (s[DW] != s[DW-1]) return s[DW] ? F_MIN : F_MAX;
		else return s[DW-1:0];
	endfunction

	function automatic fx_t ssub(input fx_t a, input fx_t b);
		logic [DW:0] s;
		s = {a[DW-1], a} - {b[DW-1], b};
		if (s[DW] != s[DW-1]) return s[DW] ? F_MIN : F_MAX;
		else return s[DW-1:0];
	endfunction

	function automatic fx_t smul(input fx_t a, input fx_t b);
		logic signed [2*DW-1:0] pr;
		logic signed [2*DW-1:0] t;
		pr = $signed({{DW{a[DW-1]}}, a}) * $signed({{DW{b[DW-1]}}, b});
		t = pr[2*DW-1] ? ((pr + RND) >>> FB) : (pr >>> FB);
		return sat_wide(t);
	endfunction

endpackage
`default_nettype wire

// ----- rtl/mhd_x_flux_glm.sv -----
// channel   direction  handshake                 payload
// in        input      in_valid / in_ready       in_data (cell_t)
// out       output     out_valid / out_ready     out_data (flux_t)
// cfg       input      cfg_we                    cfg_index, cfg_wdata
//
// one transaction per cycle accepted while the output is not stalled; the pipeline is the
// 48-step pipelined restoring divider (velocities), one sign stage, nine
// flux stages and the output register
// reset clears the valid bits and loads the register defaults
// a stalled output freezes the whole pipeline; in_ready = !out_valid | out_ready
`default_nettype none
module mhd_x_flux_glm (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire mfx_pkg::cell_t                in_data,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output mfx_pkg::flux_t                     out_data,
	input  wire logic                          cfg_we,
	input  wire logic [mfx_pkg::IDX_W-1:0]     cfg_index,
	input  wire logic [mfx_pkg::CFG_W-1:0]     cfg_wdata
);
	import mfx_pkg::*;

	logic [GW-1:0]     gamma_q;
	logic              clean_en_q;
	logic [CFG_W-1:0]  clean_speed_q;
	logic              out_valid_q;
	flux_t             out_data_q;

	logic              en;
	cell_t             cell_f;
	logic [2:0][DW-1:0] num_mag;
	logic [2:0]        num_neg;
	cell_t             side_s [NUM_W+1];
	logic              div_valid;
	fx_t [2:0]         vel;
	logic              flux_valid;
	flux_t             flux;
	logic signed [GW:0] gdiff;
	fx_t               gm1;
	fx_t               chq;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gamma_q       <= GW'(109227);
			clean_en_q    <= 1'b0;
			clean_speed_q <= CFG_W'(65536);
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_GAMMA:       gamma_q       <= cfg_wdata[GW-1:0];
				REG_CLEAN_EN:    clean_en_q    <= cfg_wdata[0];
				REG_CLEAN_SPEED: clean_speed_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign gdiff = $signed({1'b0, gamma_q}) - (GW+1)'(F_ONE);
	assign gm1   = DW'(gdiff);
	assign chq   = {1'b0, clean_speed_q};

	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	always_comb begin
		cell_f = in_data;
		if (in_data.density < F_LSB) cell_f.density = F_LSB;
		num_neg[0] = in_data.momentum_x[DW-1];
		num_neg[1] = in_data.momentum_y[DW-1];
		num_neg[2] = in_data.momentum_z[DW-1];
		num_mag[0] = num_neg[0] ? -in_data.momentum_x : in_data.momentum_x;
		num_mag[1] = num_neg[1] ? -in_data.momentum_y : in_data.momentum_y;
		num_mag[2] = num_neg[2] ? -in_data.momentum_z : in_data.momentum_z;
	end

	mfx_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (in_valid),
		.num_mag   (num_mag),
		.num_neg   (num_neg),
		.dvs       (cell_f.density[DW-2:0]),
		.out_valid (div_valid),
		.vel       (vel)
	);

	// cell data rides alongside the divider
	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= cell_f;
			for (int k = 1; k <= NUM_W; k++) side_s[k] <= side_s[k-1];
		end
	end

	mfx_flux u_flux (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (div_valid),
		.vel       (vel),
		.cell_in   (side_s[NUM_W]),
		.gm1       (gm1),
		.clean_en  (clean_en_q),
		.chq       (chq),
		.out_valid (flux_valid),
		.flux      (flux)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= flux_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) out_data_q <= flux;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule
`default_nettype wire

// ----- rtl/mfx_div.sv -----
`default_nettype none
module mfx_div (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             en,
	input  wire logic                             in_valid,
	input  wire logic [2:0][mfx_pkg::DW-1:0]      num_mag,
	input  wire logic [2:0]                       num_neg,
	input  wire logic [mfx_pkg::DW-2:0]           dvs,
	output logic                                  out_valid,
	output mfx_pkg::fx_t [2:0]                    vel
);
	import mfx_pkg::*;

	logic [2:0][DW-2:0]    rem_s [NUM_W];
	logic [2:0][NUM_W-1:0] nq_s  [NUM_W];
	logic [DW-2:0]         dvs_s [NUM_W];
	logic [2:0]            neg_s [NUM_W];
	logic                  vld_s [NUM_W];

	logic                  vld_q;
	fx_t [2:0]             vel_q;

	for (genvar k = 0; k < NUM_W; k++) begin : g_step
		logic [2:0][DW-2:0]    rem_in;
		logic [2:0][NUM_W-1:0] nq_in;
		logic [DW-2:0]         dvs_in;
		logic [2:0]            neg_in;
		logic                  vld_in;
		logic [2:0][DW-2:0]    rem_nx;
		logic [2:0][NUM_W-1:0] nq_nx;

		if (k == 0) begin : g_first
			assign rem_in = '0;
			assign nq_in  = {{num_mag[2], {FB{1'b0}}}, {num_mag[1], {FB{1'b0}}},
				{num_mag[0], {FB{1'b0}}}};
			assign dvs_in = dvs;
			assign neg_in = num_neg;
			assign vld_in = in_valid;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign nq_in  = nq_s[k-1];
			assign dvs_in = dvs_s[k-1];
			assign neg_in = neg_s[k-1];
			assign vld_in = vld_s[k-1];
		end

		always_comb begin
			logic [DW-1:0] trial;
			logic [DW:0]   diff;
			for (int l = 0; l < 3; l++) begin
				trial = {rem_in[l], nq_in[l][NUM_W-1]};
				diff  = {1'b0, trial} - {2'b00, dvs_in};
				if (!diff[DW]) begin
					rem_nx[l] = diff[DW-2:0];
					nq_nx[l]  = {nq_in[l][NUM_W-2:0], 1'b1};
				end else begin
					rem_nx[l] = trial[DW-2:0];
					nq_nx[l]  = {nq_in[l][NUM_W-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= rem_nx;
				nq_s[k]  <= nq_nx;
				dvs_s[k] <= dvs_in;
				neg_s[k] <= neg_in;
			end
		end
	end

	// sign and saturate the quotient
	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				if (|nq_s[NUM_W-1][l][NUM_W-1:DW-1]) begin
					vel_q[l] <= neg_s[NUM_W-1][l] ? F_MIN : F_MAX;
				end else if (neg_s[NUM_W-1][l]) begin
					vel_q[l] <= -fx_t'(nq_s[NUM_W-1][l][DW-1:0]);
				end else begin
					vel_q[l] <= fx_t'(nq_s[NUM_W-1][l][DW-1:0]);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_s[NUM_W-1];
		end
	end

	assign out_valid = vld_q;
	assign vel       = vel_q;

endmodule
`default_nettype wire

// ----- rtl/mfx_flux.sv -----
`default_nettype none
module mfx_flux (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                en,
	input  wire logic                in_valid,
	input  wire mfx_pkg::fx_t [2:0]  vel,
	input  wire mfx_pkg::cell_t      cell_in,
	input  wire mfx_pkg::fx_t        gm1,
	input  wire logic                clean_en,
	input  wire mfx_pkg::fx_t        chq,
	output logic                     out_valid,
	output mfx_pkg::flux_t           flux
);
	import mfx_pkg::*;

	typedef struct packed {
		fx_t rho, e, bx, by, bz, psi, vx, vy, vz;
		fx_t vxvx, vyvy, vzvz, bxbx, byby, bzbz, fm;
		fx_t vxbx, vyby, vzbz, byvx, vybx, bzvx, vzbx, bybx, bzbx, chch;
		fx_t v2, b2, vb, fmvx, fmvy, fmvz, f2, f3, f6, f7, chbx;
		fx_t keh, bh, d, p, pt, f1, ep, epvx, vbbx, f4;
	} stage_t;

	stage_t st_s1, st_s2, st_s3, st_s4, st_s5, st_s6, st_s7, st_s8, st_s9;
	stage_t nx1, nx2, nx3, nx4, nx5, nx6, nx7, nx8, nx9;
	logic [8:0] vld_s;

	always_comb begin
		nx1       = '0;
		nx1.rho   = cell_in.density;
		nx1.e     = cell_in.total_energy;
		nx1.bx    = cell_in.field_x;
		nx1.by    = cell_in.field_y;
		nx1.bz    = cell_in.field_z;
		nx1.psi   = cell_in.cleaning_scalar;
		nx1.vx    = vel[0];
		nx1.vy    = vel[1];
		nx1.vz    = vel[2];
		nx1.vxvx  = smul(vel[0], vel[0]);
		nx1.vyvy  = smul(vel[1], vel[1]);
		nx1.vzvz  = smul(vel[2], vel[2]);
		nx1.bxbx  = smul(cell_in.field_x, cell_in.field_x);
		nx1.byby  = smul(cell_in.field_y, cell_in.field_y);
		nx1.bzbz  = smul(cell_in.field_z, cell_in.field_z);
		nx1.fm    = smul(cell_in.density, vel[0]);
		nx1.vxbx  = smul(vel[0], cell_in.field_x);
		nx1.vyby  = smul(vel[1], cell_in.field_y);
		nx1.vzbz  = smul(vel[2], cell_in.field_z);
		nx1.byvx  = smul(cell_in.field_y, vel[0]);
		nx1.vybx  = smul(vel[1], cell_in.field_x);
		nx1.bzvx  = smul(cell_in.field_z, vel[0]);
		nx1.vzbx  = smul(vel[2], cell_in.field_x);
		nx1.bybx  = smul(cell_in.field_y, cell_in.field_x);
		nx1.bzbx  = smul(cell_in.field_z, cell_in.field_x);
		nx1.chch  = smul(chq, chq);
	end

	always_comb begin
		nx2      = st_s1;
		nx2.v2   = sadd(sadd(st_s1.vxvx, st_s1.vyvy), st_s1.vzvz);
		nx2.b2   = sadd(sadd(st_s1.bxbx, st_s1.byby), st_s1.bzbz);
		nx2.vb   = sadd(sadd(st_s1.vxbx, st_s1.vyby), st_s1.vzbz);
		nx2.fmvx = smul(st_s1.fm, st_s1.vx);
		nx2.fmvy = smul(st_s1.fm, st_s1.vy);
		nx2.fmvz = smul(st_s1.fm, st_s1.vz);
		nx2.f6   = ssub(st_s1.byvx, st_s1.vybx);
		nx2.f7   = ssub(st_s1.bzvx, st_s1.vzbx);
		nx2.chbx = smul(st_s1.chch, st_s1.bx);
	end

	always_comb begin
		fx_t kin;
		kin     = smul(st_s2.rho, st_s2.v2);
		nx3     = st_s2;
		// both halved values are never negative
		nx3.keh = {1'b0, kin[DW-1:1]};
		nx3.bh  = {1'b0, st_s2.b2[DW-1:1]};
		nx3.f2  = ssub(st_s2.fmvy, st_s2.bybx);
		nx3.f3  = ssub(st_s2.fmvz, st_s2.bzbx);
	end

	always_comb begin
		nx4   = st_s3;
		nx4.d = ssub(ssub(st_s3.e, st_s3.keh), st_s3.bh);
	end

	always_comb begin
		fx_t pr;
		pr    = smul(gm1, st_s4.d);
		nx5   = st_s4;
		nx5.p = (pr < F_LSB) ? F_LSB : pr;
	end

	always_comb begin
		nx6    = st_s5;
		nx6.pt = sadd(st_s5.p, st_s5.bh);
	end

	always_comb begin
		nx7    = st_s6;
		nx7.f1 = ssub(sadd(st_s6.fmvx, st_s6.pt), st_s6.bxbx);
		nx7.ep = sadd(st_s6.e, st_s6.pt);
	end

	always_comb begin
		nx8      = st_s7;
		nx8.epvx = smul(st_s7.ep, st_s7.vx);
		nx8.vbbx = smul(st_s7.vb, st_s7.bx);
	end

	always_comb begin
		nx9    = st_s8;
		nx9.f4 = ssub(st_s8.epvx, st_s8.vbbx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[7:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s1 <= nx1;
			st_s2 <= nx2;
			st_s3 <= nx3;
			st_s4 <= nx4;
			st_s5 <= nx5;
			st_s6 <= nx6;
			st_s7 <= nx7;
			st_s8 <= nx8;
			st_s9 <= nx9;
		end
	end

	always_comb begin
		flux.flux_mass     = st_s9.fm;
		flux.flux_mom_x    = st_s9.f1;
		flux.flux_mom_y    = st_s9.f2;
		flux.flux_mom_z    = st_s9.f3;
		flux.flux_energy   = st_s9.f4;
		flux.flux_field_x  = clean_en ? st_s9.psi : '0;
		flux.flux_field_y  = st_s9.f6;
		flux.flux_field_z  = st_s9.f7;
		flux.flux_cleaning = clean_en ? st_s9.chbx : '0;
	end

	assign out_valid = vld_s[8];

endmodule
`default_nettype wire
